@@ rtl/core/bae_pkg.sv @@
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types and constants of the binary arithmetic encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bae_pkg;

    // Input command codes
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Interval boundaries
    localparam logic [31:0] IV_TOP  = 32'hFFFF_FFFF;
    localparam logic [31:0] IV_HALF = 32'h8000_0000;
    localparam logic [31:0] IV_Q1   = 32'h4000_0000;
    localparam logic [31:0] IV_Q3   = 32'hC000_0000;

    // Radix-4 divider: 32 low dividend bits, two per cycle
    localparam int          DIV_STEPS = 16;
    localparam int          DIV_CNT_W = 4;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic        command;
        logic        bit_value;
        logic [15:0] freq_zero;
        logic [16:0] total;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic        lead_bit;
        logic [31:0] follower_count;
        logic        last_of_run;
        logic        stream_end;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_UPD,
        ST_NORM,
        ST_FIN
    } t_back_state;

    typedef enum logic [1:0] {
        NS_EMIT0,
        NS_EMIT1,
        NS_PEND,
        NS_DONE
    } t_norm_step;

endpackage

`default_nettype wire

@@ rtl/core/bae_in_if.sv @@
// ----------------------------------------------------------------------------
// bae_in_if
// Input channel of the encoder: valid/ready handshake with command payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface bae_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        bit_value;
    logic [15:0] freq_zero;
    logic [15:0] freq_one;

    modport source (output valid, command, bit_value, freq_zero, freq_one, input ready);
    modport sink   (input valid, command, bit_value, freq_zero, freq_one, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bae_out_if.sv @@
// ----------------------------------------------------------------------------
// bae_out_if
// Output channel of the encoder: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface bae_out_if;
    logic        valid;
    logic        ready;
    logic        lead_bit;
    logic [31:0] follower_count;
    logic        last_of_run;
    logic        stream_end;

    modport source (output valid, lead_bit, follower_count, last_of_run, stream_end,
                    input ready);
    modport sink   (input valid, lead_bit, follower_count, last_of_run, stream_end,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/bae_front.sv @@
// ----------------------------------------------------------------------------
// bae_front
// Accept input items, clamp zero frequencies and form the frequency total.
// ----------------------------------------------------------------------------
`default_nettype none

module bae_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic          i_command,
    input  wire logic          i_bit_value,
    input  wire logic [15:0]   i_freq_zero,
    input  wire logic [15:0]   i_freq_one,
    output logic               o_rdy,
    output logic               o_cmd_vld,
    output bae_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_rdy
);

    logic          r_vld;
    logic          n_vld;
    bae_pkg::t_cmd r_cmd;
    bae_pkg::t_cmd n_cmd;
    logic [15:0]   w_f0;
    logic [15:0]   w_f1;

    assign w_f0 = (i_freq_zero == 16'd0) ? 16'd1 : i_freq_zero;
    assign w_f1 = (i_freq_one  == 16'd0) ? 16'd1 : i_freq_one;

    assign o_rdy     = !r_vld || i_cmd_rdy;
    assign o_cmd_vld = r_vld;
    assign o_cmd     = r_cmd;

    always_comb begin
        n_vld = r_vld;
        n_cmd = r_cmd;
        if (r_vld && i_cmd_rdy) begin
            n_vld = 1'b0;
        end
        if (i_vld && o_rdy) begin
            n_vld           = 1'b1;
            n_cmd.command   = i_command;
            n_cmd.bit_value = i_bit_value;
            n_cmd.freq_zero = w_f0;
            n_cmd.total     = {1'b0, w_f0} + {1'b0, w_f1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_cmd <= n_cmd;
    end

endmodule

`default_nettype wire

@@ rtl/core/bae_queue.sv @@
// ----------------------------------------------------------------------------
// bae_queue
// Small FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bae_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_vld,
    input  wire bae_pkg::t_cmd i_wr_data,
    output logic               o_wr_rdy,
    output logic               o_rd_vld,
    output bae_pkg::t_cmd      o_rd_data,
    input  wire logic          i_rd_rdy
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bae_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_wr_rdy  = (r_cnt != CNT_W'(DEPTH));
    assign o_rd_vld  = (r_cnt != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign w_wr      = i_wr_vld && o_wr_rdy;
    assign w_rd      = o_rd_vld && i_rd_rdy;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_rd) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bae_back.sv @@
// ----------------------------------------------------------------------------
// bae_back
// Narrow the interval (multiply, radix-4 divide), renormalize one bit per
// cycle unless stalled by output; settled bits go via staging and output regs.
// ----------------------------------------------------------------------------
`default_nettype none

module bae_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_vld,
    input  wire bae_pkg::t_cmd i_cmd,
    output logic               o_cmd_rdy,
    output logic               o_res_vld,
    output bae_pkg::t_res      o_res,
    input  wire logic          i_res_rdy
);

    bae_pkg::t_back_state r_state;
    bae_pkg::t_back_state n_state;

    logic [31:0]                 r_low,   n_low;
    logic [31:0]                 r_high,  n_high;
    logic [31:0]                 r_pend,  n_pend;
    logic                        r_bit,   n_bit;
    logic [15:0]                 r_f0,    n_f0;
    logic [16:0]                 r_total, n_total;
    logic [32:0]                 r_range, n_range;
    logic [16:0]                 r_rem,   n_rem;
    logic [31:0]                 r_num,   n_num;
    logic [31:0]                 r_quo,   n_quo;
    logic [bae_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                        r_stg_vld, n_stg_vld;
    bae_pkg::t_res               r_stg,   n_stg;
    logic                        r_out_vld, n_out_vld;
    bae_pkg::t_res               r_out,   n_out;

    logic                 w_out_free;
    logic [47:0]          w_mul;
    logic [48:0]          w_prod;
    logic [17:0]          w_t1;
    logic [17:0]          w_t2;
    logic                 w_ge1;
    logic                 w_ge2;
    logic [16:0]          w_rem1;
    logic [16:0]          w_rem2;
    bae_pkg::t_norm_step  w_step;
    logic [31:0]          w_sub;
    logic [31:0]          w_lo_sub;
    logic [31:0]          w_hi_sub;
    logic [31:0]          w_pend_inc;

    assign w_out_free = !r_out_vld || i_res_rdy;
    assign o_cmd_rdy  = (r_state == bae_pkg::ST_IDLE);
    assign o_res_vld  = r_out_vld;
    assign o_res      = r_out;

    // Product range * freq_zero; range bit 32 only in the full interval
    assign w_mul  = 48'(r_range[31:0]) * 48'(r_f0);
    assign w_prod = {1'b0, w_mul} + (r_range[32] ? {1'b0, r_f0, 32'd0} : 49'd0);

    // Two restoring division steps per cycle
    assign w_t1   = {r_rem, r_num[31]};
    assign w_ge1  = (w_t1 >= {1'b0, r_total});
    assign w_rem1 = w_ge1 ? 17'(w_t1 - {1'b0, r_total}) : w_t1[16:0];
    assign w_t2   = {w_rem1, r_num[30]};
    assign w_ge2  = (w_t2 >= {1'b0, r_total});
    assign w_rem2 = w_ge2 ? 17'(w_t2 - {1'b0, r_total}) : w_t2[16:0];

    // Renormalization step classification
    always_comb begin
        if (r_high < bae_pkg::IV_HALF) begin
            w_step = bae_pkg::NS_EMIT0;
            w_sub  = 32'd0;
        end else if (r_low >= bae_pkg::IV_HALF) begin
            w_step = bae_pkg::NS_EMIT1;
            w_sub  = bae_pkg::IV_HALF;
        end else if (r_low >= bae_pkg::IV_Q1 && r_high < bae_pkg::IV_Q3) begin
            w_step = bae_pkg::NS_PEND;
            w_sub  = bae_pkg::IV_Q1;
        end else begin
            w_step = bae_pkg::NS_DONE;
            w_sub  = 32'd0;
        end
    end

    assign w_lo_sub   = r_low - w_sub;
    assign w_hi_sub   = r_high - w_sub;
    assign w_pend_inc = (r_pend == bae_pkg::IV_TOP) ? r_pend : r_pend + 32'd1;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bae_pkg::ST_IDLE: begin
                if (i_cmd_vld) begin
                    n_state = (i_cmd.command == bae_pkg::CMD_FINISH) ?
                              bae_pkg::ST_FIN : bae_pkg::ST_MUL;
                end
            end
            bae_pkg::ST_MUL: begin
                n_state = bae_pkg::ST_DIV;
            end
            bae_pkg::ST_DIV: begin
                if (r_cnt == bae_pkg::DIV_CNT_W'(bae_pkg::DIV_STEPS - 1)) begin
                    n_state = bae_pkg::ST_UPD;
                end
            end
            bae_pkg::ST_UPD: begin
                n_state = bae_pkg::ST_NORM;
            end
            bae_pkg::ST_NORM: begin
                if (w_step == bae_pkg::NS_DONE && (!r_stg_vld || w_out_free)) begin
                    n_state = bae_pkg::ST_IDLE;
                end
            end
            bae_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = bae_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bae_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and result registers
    always_comb begin
        n_low     = r_low;
        n_high    = r_high;
        n_pend    = r_pend;
        n_bit     = r_bit;
        n_f0      = r_f0;
        n_total   = r_total;
        n_range   = r_range;
        n_rem     = r_rem;
        n_num     = r_num;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_stg_vld = r_stg_vld;
        n_stg     = r_stg;
        n_out_vld = r_out_vld;
        n_out     = r_out;

        if (r_out_vld && i_res_rdy) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            bae_pkg::ST_IDLE: begin
                if (i_cmd_vld) begin
                    n_bit   = i_cmd.bit_value;
                    n_f0    = i_cmd.freq_zero;
                    n_total = i_cmd.total;
                    n_range = {1'b0, r_high} - {1'b0, r_low} + 33'd1;
                end
            end
            bae_pkg::ST_MUL: begin
                n_rem = w_prod[48:32];
                n_num = w_prod[31:0];
                n_quo = 32'd0;
                n_cnt = '0;
            end
            bae_pkg::ST_DIV: begin
                n_rem = w_rem2;
                n_num = {r_num[29:0], 2'b00};
                n_quo = {r_quo[29:0], w_ge1, w_ge2};
                n_cnt = r_cnt + bae_pkg::DIV_CNT_W'(1);
            end
            bae_pkg::ST_UPD: begin
                // A one takes the upper share: high stays, low moves up
                if (r_bit) begin
                    n_low = r_low + r_quo;
                end else begin
                    n_high = r_low + r_quo - 32'd1;
                end
            end
            bae_pkg::ST_NORM: begin
                case (w_step)
                    bae_pkg::NS_EMIT0, bae_pkg::NS_EMIT1: begin
                        if (!r_stg_vld || w_out_free) begin
                            if (r_stg_vld) begin
                                n_out_vld         = 1'b1;
                                n_out             = r_stg;
                                n_out.last_of_run = 1'b0;
                            end
                            n_stg_vld            = 1'b1;
                            n_stg.lead_bit       = (w_step == bae_pkg::NS_EMIT1);
                            n_stg.follower_count = r_pend;
                            n_stg.last_of_run    = 1'b0;
                            n_stg.stream_end     = 1'b0;
                            n_pend               = 32'd0;
                            n_low                = {w_lo_sub[30:0], 1'b0};
                            n_high               = {w_hi_sub[30:0], 1'b1};
                        end
                    end
                    bae_pkg::NS_PEND: begin
                        n_pend = w_pend_inc;
                        n_low  = {w_lo_sub[30:0], 1'b0};
                        n_high = {w_hi_sub[30:0], 1'b1};
                    end
                    default: begin
                        // Flush the held result as the last one of the item
                        if (r_stg_vld && w_out_free) begin
                            n_out_vld         = 1'b1;
                            n_out             = r_stg;
                            n_out.last_of_run = 1'b1;
                            n_stg_vld         = 1'b0;
                        end
                    end
                endcase
            end
            bae_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_out_vld            = 1'b1;
                    n_out.lead_bit       = (r_low >= bae_pkg::IV_Q1);
                    n_out.follower_count = w_pend_inc;
                    n_out.last_of_run    = 1'b1;
                    n_out.stream_end     = 1'b1;
                    n_low                = 32'd0;
                    n_high               = bae_pkg::IV_TOP;
                    n_pend               = 32'd0;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bae_pkg::ST_IDLE;
            r_low     <= 32'd0;
            r_high    <= bae_pkg::IV_TOP;
            r_pend    <= 32'd0;
            r_cnt     <= '0;
            r_stg_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_low     <= n_low;
            r_high    <= n_high;
            r_pend    <= n_pend;
            r_cnt     <= n_cnt;
            r_stg_vld <= n_stg_vld;
            r_out_vld <= n_out_vld;
        end
        r_bit   <= n_bit;
        r_f0    <= n_f0;
        r_total <= n_total;
        r_range <= n_range;
        r_rem   <= n_rem;
        r_num   <= n_num;
        r_quo   <= n_quo;
        r_stg   <= n_stg;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

@@ rtl/core/binary_arithmetic_encoder_top.sv @@
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder_top
// 32-bit binary arithmetic encoder with deferred (underflow) bit handling.
// ----------------------------------------------------------------------------
// Encode item: front register, queue, dequeue, multiply, radix-4 divide loop,
//   update, then one renormalization shift per cycle unless the output
//   stalls, and a closing step.
// Finish item: dequeue, then the finish state. Throughput is one item per back
//   pass; the front and queue take new items while the back is busy.
// Reset (synchronous, active low): interval [0, 0xFFFFFFFF], no pending bits,
//   queue, staging and output registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_arithmetic_encoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bae_in_if.sink    i_in,
    bae_out_if.source o_out
);

    // Front to queue
    logic          w_fq_vld;
    logic          w_fq_rdy;
    bae_pkg::t_cmd w_fq_cmd;

    // Queue to back
    logic          w_qb_vld;
    logic          w_qb_rdy;
    bae_pkg::t_cmd w_qb_cmd;

    // Back to output channel
    logic          w_res_vld;
    bae_pkg::t_res w_res;

    // Front: accept items, clamp zero frequencies, form the total
    bae_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (i_in.valid),
        .i_command   (i_in.command),
        .i_bit_value (i_in.bit_value),
        .i_freq_zero (i_in.freq_zero),
        .i_freq_one  (i_in.freq_one),
        .o_rdy       (i_in.ready),
        .o_cmd_vld   (w_fq_vld),
        .o_cmd       (w_fq_cmd),
        .i_cmd_rdy   (w_fq_rdy)
    );

    // Queue: decouple the front from the multi-cycle back
    bae_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_vld  (w_fq_vld),
        .i_wr_data (w_fq_cmd),
        .o_wr_rdy  (w_fq_rdy),
        .o_rd_vld  (w_qb_vld),
        .o_rd_data (w_qb_cmd),
        .i_rd_rdy  (w_qb_rdy)
    );

    // Back: interval arithmetic, renormalization, result delivery
    bae_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (w_qb_vld),
        .i_cmd     (w_qb_cmd),
        .o_cmd_rdy (w_qb_rdy),
        .o_res_vld (w_res_vld),
        .o_res     (w_res),
        .i_res_rdy (o_out.ready)
    );

    // Drive the output channel straight from the back's output register
    assign o_out.valid          = w_res_vld;
    assign o_out.lead_bit       = w_res.lead_bit;
    assign o_out.follower_count = w_res.follower_count;
    assign o_out.last_of_run    = w_res.last_of_run;
    assign o_out.stream_end     = w_res.stream_end;

endmodule

`default_nettype wire
